/* design/cbm_pkg.sv */
// Shared types and constants of the cartridge bank mapper.
// Used by the translate, register and top-level modules; no dependencies.
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int PAGE_BITS  = 14;
  localparam int PAGE_W     = 6;
  localparam int PHYS_W     = 20;

  localparam logic [15:0] ADDR_SLOT0_SEL = 16'h0000;
  localparam logic [15:0] ADDR_SLOT1_SEL = 16'h4000;
  localparam logic [15:0] ADDR_SLOT2_SEL = 16'h8000;
  localparam logic [15:0] ADDR_LOW_ROM   = 16'h0400;
  localparam logic [15:0] ADDR_CTRL      = 16'hFFFC;
  localparam logic [15:0] ADDR_PAGE0     = 16'hFFFD;
  localparam logic [15:0] ADDR_PAGE1     = 16'hFFFE;
  localparam logic [15:0] ADDR_PAGE2     = 16'hFFFF;

  localparam logic CFG_CODEMASTERS = 1'b0;
  localparam logic CFG_LARGE_ROM   = 1'b1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    TGT_DROP = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_CRAM = 2'd2,
    TGT_SRAM = 2'd3
  } tgt_t;

  typedef enum logic [1:0] {
    SRC_ROM   = 2'd0,
    SRC_BANK0 = 2'd1,
    SRC_BANK1 = 2'd2
  } src_t;

  typedef struct packed {
    logic              cm;
    logic              large_rom;
    logic [PAGE_W-1:0] p0;
    logic [PAGE_W-1:0] p1;
    logic [PAGE_W-1:0] p2;
    src_t              src;
    logic [7:0]        ctrl;
  } map_state_t;

  typedef struct packed {
    logic              p0_we;
    logic              p1_we;
    logic              p2_we;
    logic              src_we;
    logic              ctrl_we;
    logic [PAGE_W-1:0] page;
    src_t              src;
    logic [7:0]        ctrl;
  } map_upd_t;

  typedef struct packed {
    tgt_t              target;
    logic [PHYS_W-1:0] phys;
    logic              do_write;
    logic [7:0]        store;
  } map_res_t;

endpackage

/* design/cbm_translate.sv */
// Combinational translation of one access into a memory command and paging updates.
// Depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_translate
  import cbm_pkg::*;
#(
  parameter int ROM_ADDR_BITS = 20
) (
  input  logic       op,
  input  logic [15:0] addr,
  input  logic [7:0]  wbyte,
  input  map_state_t  st,
  output map_res_t    res,
  output map_upd_t    upd
);

  localparam logic [PHYS_W:0] ROM_MASK_W = (21'd1 << ROM_ADDR_BITS) - 21'd1;
  localparam logic [PHYS_W-1:0] ROM_MASK = ROM_MASK_W[PHYS_W-1:0];

  logic [PAGE_W-1:0] page_sel;
  logic [PAGE_W-1:0] page_val;
  logic [PHYS_W-1:0] cram_off;
  logic [PHYS_W-1:0] sram_off;

  function automatic logic [PHYS_W-1:0] rom_addr(input logic [PAGE_W-1:0] page,
                                                 input logic [15:0] a);
    rom_addr = {page, a[PAGE_BITS-1:0]} & ROM_MASK;
  endfunction

  assign page_val = st.large_rom ? wbyte[PAGE_W-1:0] : {1'b0, wbyte[PAGE_W-2:0]};
  assign cram_off = {5'd0, (st.src == SRC_BANK1), addr[13:0]};
  assign sram_off = {7'd0, addr[12:0]};

  always_comb begin
    unique case (addr[15:14])
      2'd0:    page_sel = st.p0;
      2'd1:    page_sel = st.p1;
      default: page_sel = st.p2;
    endcase
  end

  always_comb begin
    res.target   = TGT_DROP;
    res.phys     = '0;
    res.do_write = 1'b0;
    res.store    = '0;
    upd.p0_we    = 1'b0;
    upd.p1_we    = 1'b0;
    upd.p2_we    = 1'b0;
    upd.src_we   = 1'b0;
    upd.ctrl_we  = 1'b0;
    upd.page     = page_val;
    upd.src      = SRC_ROM;
    upd.ctrl     = wbyte;
    if (op == OP_READ) begin
      if (addr[15:14] == 2'd3) begin
        res.target = TGT_SRAM;
        res.phys   = sram_off;
      end else if (!st.cm && addr < ADDR_LOW_ROM) begin
        res.target = TGT_ROM;
        res.phys   = {4'd0, addr};
      end else if (addr[15:14] == 2'd2 && st.src != SRC_ROM) begin
        res.target = TGT_CRAM;
        res.phys   = cram_off;
      end else begin
        res.target = TGT_ROM;
        res.phys   = rom_addr(page_sel, addr);
      end
    end else begin
      if (st.cm) begin
        upd.p0_we  = (addr == ADDR_SLOT0_SEL);
        upd.p1_we  = (addr == ADDR_SLOT1_SEL);
        upd.p2_we  = (addr == ADDR_SLOT2_SEL);
        upd.src_we = (addr == ADDR_SLOT2_SEL);
      end
      if (addr[15:14] == 2'd2) begin
        if (!(st.cm && addr == ADDR_SLOT2_SEL) && st.src != SRC_ROM) begin
          res.target   = TGT_CRAM;
          res.phys     = cram_off;
          res.do_write = 1'b1;
          res.store    = wbyte;
        end
      end else if (addr[15:14] == 2'd3) begin
        upd.ctrl_we  = (addr == ADDR_CTRL);
        res.target   = TGT_SRAM;
        res.phys     = sram_off;
        res.do_write = 1'b1;
        res.store    = wbyte;
        if (!st.cm) begin
          upd.src_we = (addr == ADDR_CTRL);
          upd.src    = wbyte[3] ? (wbyte[2] ? SRC_BANK1 : SRC_BANK0) : SRC_ROM;
          upd.p0_we  = (addr == ADDR_PAGE0);
          upd.p1_we  = (addr == ADDR_PAGE1);
          upd.p2_we  = (addr == ADDR_PAGE2);
        end
      end
    end
  end

endmodule

/* design/cbm_map_regs.sv */
// Paging and configuration registers of the cartridge bank mapper.
// Depends on cbm_pkg; updates come from cbm_translate.
`timescale 1ns / 1ps

module cbm_map_regs
  import cbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  input  logic       upd_en,
  input  map_upd_t   upd,
  output map_state_t st
);

  map_state_t st_r;
  map_state_t st_nxt;

  always_comb begin
    st_nxt = st_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODEMASTERS: st_nxt.cm        = cfg_wdata;
        CFG_LARGE_ROM:   st_nxt.large_rom = cfg_wdata;
        default:         st_nxt.cm        = st_r.cm;
      endcase
    end
    if (upd_en) begin
      if (upd.p0_we)   st_nxt.p0   = upd.page;
      if (upd.p1_we)   st_nxt.p1   = upd.page;
      if (upd.p2_we)   st_nxt.p2   = upd.page;
      if (upd.src_we)  st_nxt.src  = upd.src;
      if (upd.ctrl_we) st_nxt.ctrl = upd.ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cm        <= 1'b0;
      st_r.large_rom <= 1'b0;
      st_r.p0        <= PAGE_W'(0);
      st_r.p1        <= PAGE_W'(1);
      st_r.p2        <= PAGE_W'(2);
      st_r.src       <= SRC_ROM;
      st_r.ctrl      <= 8'd0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

endmodule

/* design/cartridge_bank_mapper_unit.sv */
// Top level of the cartridge bank mapper: input stage, translation, result stage.
// Depends on cbm_pkg, cbm_translate and cbm_map_regs.
`timescale 1ns / 1ps

// Accepts one access beat per clock while the output is not stalled and returns one command
// beat per access, in order, from the result register. The beat
// sits in an input register; the translate logic reads it together with the paging
// registers, which it updates at the same edge that loads the result register, so the
// next beat always sees the paging left by the one before. Configuration writes take
// effect at the next edge; the user must keep them to idle periods; the block does not check.

module cartridge_bank_mapper_unit
  import cbm_pkg::*;
#(
  parameter int ROM_ADDR_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cpu_address[15:0], write_byte[23:16]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // phys_address[19:0], do_write[20], store_byte[28:21], zero
  output logic [1:0]  out_tuser,  // target
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  logic        s1_valid_r;
  logic        s1_op_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic        out_valid_r;
  map_res_t    out_res_r;
  logic        adv;
  map_state_t  st;
  map_res_t    res;
  map_upd_t    upd;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  cbm_translate #(
    .ROM_ADDR_BITS(ROM_ADDR_BITS)
  ) u_translate (
    .op   (s1_op_r),
    .addr (s1_addr_r),
    .wbyte(s1_data_r),
    .st   (st),
    .res  (res),
    .upd  (upd)
  );

  cbm_map_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .upd_en   (adv),
    .upd      (upd),
    .st       (st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (adv) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
    if (adv) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.target;
  assign out_tdata  = {3'd0, out_res_r.store, out_res_r.do_write, out_res_r.phys};

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.target == TGT_DROP) |->
      (out_res_r.phys == '0 && !out_res_r.do_write && out_res_r.store == 8'd0))
    else $error("dropped command carries data");

  a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.do_write) |->
      (out_res_r.target == TGT_CRAM || out_res_r.target == TGT_SRAM))
    else $error("write command aimed at ROM");

  a_ctrl_src: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_op_r == OP_WRITE && !st.cm && s1_addr_r == ADDR_CTRL) |=>
      (st.ctrl[3] ? (st.src == (st.ctrl[2] ? SRC_BANK1 : SRC_BANK0)) : (st.src == SRC_ROM)))
    else $error("slot 2 source out of step with control byte");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input held off without a downstream stall");

endmodule
